// File: design/pse_pkg.sv
// Shared constants and types of the postfix stack evaluator.
`timescale 1ns / 1ps
`default_nettype none
package pse_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CHAR_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int TDATA_OUT_W = ((DATA_W + STATUS_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_BADCHAR   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_DIV,
        S_FINISH
    } state_t;

endpackage
`default_nettype wire

// File: design/postfix_stack_evaluator_top.sv
// Top level of the postfix stack evaluator: control sequencer and datapath.
// A blank or a digit goes from idle through decode and finish; an add, subtract or multiply
// also passes read, and a divide then waits in the divide state for the radix-2 divider.
// A result is loaded into the output register in the last cycle of its request.
// The next request is taken while a result waits; only a later result waits for the slot.
// Reset clears the stack depth, the error code and the handshakes; the stack memory is not
// cleared, and no entry is read before it is written.
`timescale 1ns / 1ps
`default_nettype none
module postfix_stack_evaluator_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [pse_pkg::CHAR_W-1:0]      s_tdata,  // [7:0] char_code
    input  wire logic                           s_tlast,  // last_char
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [pse_pkg::TDATA_OUT_W-1:0] m_tdata   // [31:0] result_value, [34:32] status
);
    import pse_pkg::*;

    state_t            state_reg, state_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    status_t           err_reg, err_next;
    logic [DATA_W-1:0] tos_reg, tos_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    status_t           out_status_reg, out_status_next;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;
    logic              div_start, div_done;
    logic [DATA_W-1:0] div_quo;

    logic              in_accept;
    logic              is_blank, is_digit, is_op, is_div;
    logic              out_free;
    logic [DATA_W-1:0] prod;
    status_t           fin_status;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign is_blank  = (char_reg == CH_SPACE) || (char_reg == CH_TAB);
    assign is_digit  = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign is_div    = (char_reg == CH_SLASH);
    assign is_op     = (char_reg == CH_PLUS) || (char_reg == CH_MINUS)
                    || (char_reg == CH_STAR) || is_div;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign prod      = ram_rdata * tos_reg;
    assign fin_status = (err_reg != ST_OK) ? err_reg
                      : ((depth_reg == '0) ? ST_UNDERFLOW : ST_OK);

    pse_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_W)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pse_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (ram_rdata),
        .divisor  (tos_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (err_reg == ST_OK && !is_blank && !is_digit && is_op
                    && depth_reg >= DEPTH_W'(2)) begin
                    state_next = S_READ;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_READ: begin
                if (is_div && tos_reg != '0) begin
                    state_next = S_DIV;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!last_reg || out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        char_next       = char_reg;
        last_next       = last_reg;
        depth_next      = depth_reg;
        err_next        = err_reg;
        tos_next        = tos_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        ram_we          = 1'b0;
        ram_waddr       = ADDR_W'(depth_reg - DEPTH_W'(1));
        ram_wdata       = tos_reg;
        ram_re          = 1'b0;
        ram_raddr       = ADDR_W'(depth_reg - DEPTH_W'(2));
        div_start       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    char_next = s_tdata;
                    last_next = s_tlast;
                end
            end
            S_DECODE: begin
                if (err_reg != ST_OK || is_blank) begin
                    err_next = err_reg;
                end else if (is_digit) begin
                    if (depth_reg >= DEPTH_W'(STACK_DEPTH)) begin
                        err_next = ST_OVERFLOW;
                    end else begin
                        // The top lives in a register; the old top spills to memory.
                        ram_we     = (depth_reg != '0);
                        tos_next   = DATA_W'(char_reg - CH_ZERO);
                        depth_next = depth_reg + 1'b1;
                    end
                end else if (!is_op) begin
                    err_next = ST_BADCHAR;
                end else if (depth_reg < DEPTH_W'(2)) begin
                    err_next = ST_UNDERFLOW;
                end else begin
                    ram_re = 1'b1;
                end
            end
            S_READ: begin
                case (char_reg)
                    CH_PLUS: begin
                        tos_next   = ram_rdata + tos_reg;
                        depth_next = depth_reg - 1'b1;
                    end
                    CH_MINUS: begin
                        tos_next   = ram_rdata - tos_reg;
                        depth_next = depth_reg - 1'b1;
                    end
                    CH_STAR: begin
                        tos_next   = prod;
                        depth_next = depth_reg - 1'b1;
                    end
                    default: begin
                        if (tos_reg == '0) begin
                            err_next = ST_DIVZERO;
                        end else begin
                            div_start = 1'b1;
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    tos_next   = div_quo;
                    depth_next = depth_reg - 1'b1;
                end
            end
            S_FINISH: begin
                if (last_reg && out_free) begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = fin_status;
                    out_value_next  = (fin_status == ST_OK) ? tos_reg : '0;
                    depth_next      = '0;
                    err_next        = ST_OK;
                end
            end
            default: begin
                err_next = err_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            depth_reg    <= '0;
            err_reg      <= ST_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            depth_reg    <= depth_next;
            err_reg      <= err_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg       <= char_next;
        last_reg       <= last_next;
        tos_reg        <= tos_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(TDATA_OUT_W - DATA_W - STATUS_W){1'b0}}, out_status_reg, out_value_reg};

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_error_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_status_reg != ST_OK |-> out_value_reg == '0)
        else $error("failed expression reports a nonzero value");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg != ST_OK && state_reg != S_FINISH |=> err_reg == $past(err_reg))
        else $error("error code changed before the end of the expression");
`endif

endmodule
`default_nettype wire

// File: design/pse_stack_ram.sv
// Operand stack memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pse_stack_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: design/pse_divider.sv
// Iterative radix-2 signed divider that truncates toward zero.
`timescale 1ns / 1ps
`default_nettype none
module pse_divider (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [pse_pkg::DATA_W-1:0] dividend,
    input  wire logic [pse_pkg::DATA_W-1:0] divisor,
    output logic                           done,
    output logic      [pse_pkg::DATA_W-1:0] quotient
);
    import pse_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              fix_reg, fix_next;
    logic [CNT_W-1:0]  iter_reg, iter_next;
    logic              neg_reg, neg_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = !diff[DATA_W];

    always_comb begin
        busy_next = busy_reg;
        fix_next  = 1'b0;
        iter_next = iter_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            // Work on magnitudes; the sign is applied once at the end.
            busy_next = 1'b1;
            iter_next = '0;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            quo_next  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            den_next  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_next  = {quo_reg[DATA_W-2:0], fits};
            iter_next = iter_reg + 1'b1;
            if (iter_reg == CNT_W'(DATA_W - 1)) begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
        end
    end

    always_ff @(posedge aclk) begin
        iter_reg <= iter_next;
        neg_reg  <= neg_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done     = fix_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule
`default_nettype wire
